@@ rtl/core/r2fft_pkg.sv @@
// ----------------------------------------------------------------------------
// r2fft_pkg
// Shared types, codes and fixed widths of the radix-2 FFT/IFFT block.
// ----------------------------------------------------------------------------
package r2fft_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int WORD_W    = 28;
  localparam int TW_W      = 19;
  localparam int TW_FRAC   = 17;
  localparam int PROD_W    = WORD_W + TW_W;
  localparam int TSUM_W    = PROD_W + 1;
  localparam int T_W       = TSUM_W - TW_FRAC;
  localparam int ACC_W     = T_W + 1;
  localparam int BIN_W     = 10;
  localparam int CFG_W     = 4;
  localparam int CFG_IDX_W = 1;
  localparam int CPLX_W    = 2 * WORD_W;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_READ = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_LOG2_POINTS  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_INVERSE_MODE = 1'b1;

  localparam logic [CFG_W-1:0] LOG2_POINTS_RESET = 4'd10;

  typedef struct packed {
    logic                       cmd;
    logic signed [SAMPLE_W-1:0] sample_real;
    logic signed [SAMPLE_W-1:0] sample_imag;
  } in_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] bin_real;
    logic signed [WORD_W-1:0] bin_imag;
    logic [BIN_W-1:0]         bin_number;
    logic                     last_bin;
    logic                     frame_ready;
  } out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_REV_CHK,
    ST_REV_RD_B,
    ST_REV_WR_I,
    ST_REV_WR_R,
    ST_BF_RD_A,
    ST_BF_RD_B,
    ST_BF_MUL,
    ST_BF_SUM,
    ST_BF_WR_A,
    ST_BF_WR_B,
    ST_SC_RD,
    ST_SC_WR
  } state_t;

  typedef struct packed {
    logic cap_a;
    logic mul_en;
    logic sum_en;
  } bfly_ctl_t;

  function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    hi = ACC_W'((64'sd1 <<< (WORD_W - 1)) - 64'sd1);
    lo = -ACC_W'(64'sd1 <<< (WORD_W - 1));
    if (v > hi) begin
      sat_word = hi[WORD_W-1:0];
    end else if (v < lo) begin
      sat_word = lo[WORD_W-1:0];
    end else begin
      sat_word = v[WORD_W-1:0];
    end
  endfunction

endpackage

@@ rtl/core/radix2_fft_ifft.sv @@
// ----------------------------------------------------------------------------
// radix2_fft_ifft
// In-place radix-2 decimation-in-time FFT/IFFT over one frame held in RAM.
//
//   Channel  Handshake                 Payload
//   input    start / busy              in_data  (cmd, sample_real, sample_imag)
//   result   out_valid, one-cycle      out_data (bin fields, last_bin, frame_ready)
//   config   cfg_we                    cfg_index, cfg_data
//
// A load is written to the frame RAM at its transfer. A read of a ready
// frame holds busy through the read state, which registers the frame RAM's
// read data as its result; a read with no ready frame returns zeros on the
// cycle after the transfer. The n-th load starts the transform: the reorder
// pass swaps each pair of bit-reversed entries, the (n/2)log2(n) butterflies
// each read, multiply, sum and write back two entries, and the inverse adds a
// scaling pass. busy is high throughout. Results cannot be held off.
// ----------------------------------------------------------------------------
module radix2_fft_ifft #(
  parameter int MAX_LOG2_POINTS = 10
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  r2fft_pkg::in_t                      in_data,
  output logic                                out_valid,
  output r2fft_pkg::out_t                     out_data,
  input  logic                                cfg_we,
  input  logic [r2fft_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [r2fft_pkg::CFG_W-1:0]         cfg_data
);

  localparam int M     = MAX_LOG2_POINTS;
  localparam int NMAX  = 1 << M;
  localparam int LW    = $clog2(M + 1);
  localparam int W     = r2fft_pkg::WORD_W;
  localparam int CW    = r2fft_pkg::CPLX_W;
  localparam int EXT   = r2fft_pkg::WORD_W - r2fft_pkg::SAMPLE_W;
  localparam logic [LW-1:0] M_L = LW'(M);

  r2fft_pkg::state_t state_r, state_nxt;

  logic [r2fft_pkg::CFG_W-1:0] cfg_log2_r;
  logic                        cfg_inv_r;
  logic [M:0]                  load_cnt_r, load_cnt_nxt;
  logic [M-1:0]                read_cnt_r, read_cnt_nxt;
  logic                        valid_r, valid_nxt;
  logic [M-1:0]                idx_r, idx_nxt;
  logic [LW-1:0]               stage_r, stage_nxt;
  logic [M-2:0]                bf_r, bf_nxt;
  logic [CW-1:0]               hold_r, hold_nxt;
  logic                        out_valid_r, out_valid_nxt;
  r2fft_pkg::out_t             out_r, out_nxt;

  logic [LW-1:0]               l_eff;
  logic [M:0]                  n_pts;
  logic [M-1:0]                rev_full;
  logic [M-1:0]                rev;
  logic                        idx_last;
  logic                        bf_last;
  logic [LW-1:0]               sm1;
  logic [M-2:0]                j_mask;
  logic [M-2:0]                j_val;
  logic [M-1:0]                addr_a;
  logic [M-1:0]                addr_b;
  logic [M-2:0]                tw_idx;
  logic [M:0]                  load_inc;
  logic [M-1:0]                rc;

  logic                        ram_we;
  logic [M-1:0]                ram_waddr;
  logic [CW-1:0]               ram_wdata;
  logic [M-1:0]                ram_raddr;
  logic [CW-1:0]               ram_rdata;

  r2fft_pkg::bfly_ctl_t        bctl;
  logic signed [r2fft_pkg::TW_W-1:0] w_re;
  logic signed [r2fft_pkg::TW_W-1:0] w_im;
  logic [CW-1:0]               res_a;
  logic [CW-1:0]               res_b;
  logic signed [W-1:0]         sc_re;
  logic signed [W-1:0]         sc_im;

  r2fft_ram #(
    .WIDTH (CW),
    .DEPTH (NMAX)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  r2fft_twiddle #(
    .MAX_LOG2_POINTS (M)
  ) u_twiddle (
    .clk     (clk),
    .idx     (tw_idx),
    .inverse (cfg_inv_r),
    .w_re    (w_re),
    .w_im    (w_im)
  );

  r2fft_bfly u_bfly (
    .clk     (clk),
    .ctl     (bctl),
    .rd_data (ram_rdata),
    .w_re    (w_re),
    .w_im    (w_im),
    .res_a   (res_a),
    .res_b   (res_b)
  );

  always_comb begin
    if (cfg_log2_r == '0) begin
      l_eff = LW'(1);
    end else if (int'(cfg_log2_r) > M) begin
      l_eff = M_L;
    end else begin
      l_eff = LW'(cfg_log2_r);
    end
    n_pts = (M + 1)'(1) << l_eff;
    for (int b = 0; b < M; b++) begin
      rev_full[b] = idx_r[M-1-b];
    end
    rev      = rev_full >> (M_L - l_eff);
    idx_last = ((M + 1)'(idx_r) == n_pts - (M + 1)'(1));
    bf_last  = ((M + 1)'(bf_r) == (n_pts >> 1) - (M + 1)'(1));
    sm1      = stage_r - LW'(1);
    j_mask   = ((M - 1)'(1) << sm1) - (M - 1)'(1);
    j_val    = bf_r & j_mask;
    addr_a   = ((M'(bf_r) >> sm1) << stage_r) | M'(j_val);
    addr_b   = addr_a | (M'(1) << sm1);
    tw_idx   = j_val << (M_L - stage_r);
    load_inc = load_cnt_r + (M + 1)'(1);
    rc       = ((M + 1)'(read_cnt_r) >= n_pts) ? '0 : read_cnt_r;
    sc_re    = $signed(ram_rdata[2*W-1:W]) >>> l_eff;
    sc_im    = $signed(ram_rdata[W-1:0]) >>> l_eff;
  end

  always_comb begin
    state_nxt     = state_r;
    load_cnt_nxt  = load_cnt_r;
    read_cnt_nxt  = read_cnt_r;
    valid_nxt     = valid_r;
    idx_nxt       = idx_r;
    stage_nxt     = stage_r;
    bf_nxt        = bf_r;
    hold_nxt      = hold_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    ram_we        = 1'b0;
    ram_waddr     = idx_r;
    ram_wdata     = ram_rdata;
    ram_raddr     = idx_r;
    bctl          = '0;
    case (state_r)
      r2fft_pkg::ST_IDLE: begin
        if (start && in_data.cmd == r2fft_pkg::CMD_LOAD) begin
          ram_we    = 1'b1;
          ram_waddr = load_cnt_r[M-1:0];
          ram_wdata = {{EXT{in_data.sample_real[r2fft_pkg::SAMPLE_W-1]}}, in_data.sample_real,
                       {EXT{in_data.sample_imag[r2fft_pkg::SAMPLE_W-1]}}, in_data.sample_imag};
          valid_nxt = 1'b0;
          if (load_inc >= n_pts) begin
            load_cnt_nxt = '0;
            read_cnt_nxt = '0;
            idx_nxt      = '0;
            state_nxt    = r2fft_pkg::ST_REV_CHK;
          end else begin
            load_cnt_nxt = load_inc;
          end
        end else if (start) begin
          if (!valid_r) begin
            out_valid_nxt = 1'b1;
            out_nxt       = '0;
          end else begin
            ram_raddr    = rc;
            read_cnt_nxt = rc;
            state_nxt    = r2fft_pkg::ST_READ;
          end
        end
      end
      r2fft_pkg::ST_READ: begin
        out_valid_nxt        = 1'b1;
        out_nxt.bin_real     = ram_rdata[2*W-1:W];
        out_nxt.bin_imag     = ram_rdata[W-1:0];
        out_nxt.bin_number   = r2fft_pkg::BIN_W'(read_cnt_r);
        out_nxt.last_bin     = ((M + 1)'(read_cnt_r) == n_pts - (M + 1)'(1));
        out_nxt.frame_ready  = 1'b1;
        read_cnt_nxt         = out_nxt.last_bin ? '0 : read_cnt_r + M'(1);
        state_nxt            = r2fft_pkg::ST_IDLE;
      end
      r2fft_pkg::ST_REV_CHK: begin
        ram_raddr = idx_r;
        if (rev > idx_r) begin
          state_nxt = r2fft_pkg::ST_REV_RD_B;
        end else if (idx_last) begin
          stage_nxt = LW'(1);
          bf_nxt    = '0;
          state_nxt = r2fft_pkg::ST_BF_RD_A;
        end else begin
          idx_nxt = idx_r + M'(1);
        end
      end
      r2fft_pkg::ST_REV_RD_B: begin
        ram_raddr = rev;
        hold_nxt  = ram_rdata;
        state_nxt = r2fft_pkg::ST_REV_WR_I;
      end
      r2fft_pkg::ST_REV_WR_I: begin
        ram_we    = 1'b1;
        ram_waddr = idx_r;
        ram_wdata = ram_rdata;
        state_nxt = r2fft_pkg::ST_REV_WR_R;
      end
      r2fft_pkg::ST_REV_WR_R: begin
        ram_we    = 1'b1;
        ram_waddr = rev;
        ram_wdata = hold_r;
        if (idx_last) begin
          stage_nxt = LW'(1);
          bf_nxt    = '0;
          state_nxt = r2fft_pkg::ST_BF_RD_A;
        end else begin
          idx_nxt   = idx_r + M'(1);
          state_nxt = r2fft_pkg::ST_REV_CHK;
        end
      end
      r2fft_pkg::ST_BF_RD_A: begin
        ram_raddr = addr_a;
        state_nxt = r2fft_pkg::ST_BF_RD_B;
      end
      r2fft_pkg::ST_BF_RD_B: begin
        ram_raddr  = addr_b;
        bctl.cap_a = 1'b1;
        state_nxt  = r2fft_pkg::ST_BF_MUL;
      end
      r2fft_pkg::ST_BF_MUL: begin
        bctl.mul_en = 1'b1;
        state_nxt   = r2fft_pkg::ST_BF_SUM;
      end
      r2fft_pkg::ST_BF_SUM: begin
        bctl.sum_en = 1'b1;
        state_nxt   = r2fft_pkg::ST_BF_WR_A;
      end
      r2fft_pkg::ST_BF_WR_A: begin
        ram_we    = 1'b1;
        ram_waddr = addr_a;
        ram_wdata = res_a;
        state_nxt = r2fft_pkg::ST_BF_WR_B;
      end
      r2fft_pkg::ST_BF_WR_B: begin
        ram_we    = 1'b1;
        ram_waddr = addr_b;
        ram_wdata = res_b;
        state_nxt = r2fft_pkg::ST_BF_RD_A;
        if (!bf_last) begin
          bf_nxt = bf_r + (M - 1)'(1);
        end else if (stage_r != l_eff) begin
          bf_nxt    = '0;
          stage_nxt = stage_r + LW'(1);
        end else if (cfg_inv_r) begin
          idx_nxt   = '0;
          state_nxt = r2fft_pkg::ST_SC_RD;
        end else begin
          valid_nxt = 1'b1;
          state_nxt = r2fft_pkg::ST_IDLE;
        end
      end
      r2fft_pkg::ST_SC_RD: begin
        ram_raddr = idx_r;
        state_nxt = r2fft_pkg::ST_SC_WR;
      end
      r2fft_pkg::ST_SC_WR: begin
        ram_we    = 1'b1;
        ram_waddr = idx_r;
        ram_wdata = {sc_re, sc_im};
        if (idx_last) begin
          valid_nxt = 1'b1;
          state_nxt = r2fft_pkg::ST_IDLE;
        end else begin
          idx_nxt   = idx_r + M'(1);
          state_nxt = r2fft_pkg::ST_SC_RD;
        end
      end
      default: begin
        state_nxt = r2fft_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= r2fft_pkg::ST_IDLE;
      cfg_log2_r  <= r2fft_pkg::LOG2_POINTS_RESET;
      cfg_inv_r   <= 1'b0;
      load_cnt_r  <= '0;
      read_cnt_r  <= '0;
      valid_r     <= 1'b0;
      idx_r       <= '0;
      stage_r     <= LW'(1);
      bf_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      load_cnt_r  <= load_cnt_nxt;
      read_cnt_r  <= read_cnt_nxt;
      valid_r     <= valid_nxt;
      idx_r       <= idx_nxt;
      stage_r     <= stage_nxt;
      bf_r        <= bf_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          r2fft_pkg::CFG_LOG2_POINTS:  cfg_log2_r <= cfg_data;
          r2fft_pkg::CFG_INVERSE_MODE: cfg_inv_r  <= cfg_data[0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    hold_r <= hold_nxt;
    out_r  <= out_nxt;
  end

  assign busy      = (state_r != r2fft_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTH
  a_out_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(start && !busy && in_data.cmd == r2fft_pkg::CMD_READ) ||
                   $past(state_r == r2fft_pkg::ST_READ)))
    else $error("result transfer without a read");

  a_not_ready_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.frame_ready |-> out_data.bin_real == '0 &&
                                           out_data.bin_imag == '0 &&
                                           !out_data.last_bin)
    else $error("result of an empty frame is not all zero");

  a_no_write_in_math: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == r2fft_pkg::ST_BF_MUL || state_r == r2fft_pkg::ST_BF_SUM |-> !ram_we)
    else $error("frame RAM written during butterfly arithmetic");

  a_ready_after_xform: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(valid_r) |-> $past(state_r == r2fft_pkg::ST_BF_WR_B ||
                             state_r == r2fft_pkg::ST_SC_WR))
    else $error("frame marked ready outside the end of a transform");
`endif

endmodule

@@ rtl/core/r2fft_ram.sv @@
// ----------------------------------------------------------------------------
// r2fft_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module r2fft_ram #(
  parameter int WIDTH = 56,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/core/r2fft_twiddle.sv @@
// ----------------------------------------------------------------------------
// r2fft_twiddle
// Q1.17 twiddle lookup from a one-octant cosine/sine table, registered output.
// ----------------------------------------------------------------------------
module r2fft_twiddle #(
  parameter int MAX_LOG2_POINTS = 10
) (
  input  logic                                   clk,
  input  logic [MAX_LOG2_POINTS-2:0]             idx,
  input  logic                                   inverse,
  output logic signed [r2fft_pkg::TW_W-1:0]      w_re,
  output logic signed [r2fft_pkg::TW_W-1:0]      w_im
);

  localparam int NMAX = 1 << MAX_LOG2_POINTS;
  localparam int OCT  = NMAX / 8;
  localparam int KW   = MAX_LOG2_POINTS - 1;
  localparam int OW   = MAX_LOG2_POINTS - 2;
  localparam logic [KW:0] OCT1 = (KW + 1)'(OCT);
  localparam logic [KW:0] OCT2 = (KW + 1)'(2 * OCT);
  localparam logic [KW:0] OCT3 = (KW + 1)'(3 * OCT);
  localparam logic [KW:0] OCT4 = (KW + 1)'(4 * OCT);

  logic signed [r2fft_pkg::TW_W-1:0] cos_rom [0:OCT];
  logic signed [r2fft_pkg::TW_W-1:0] sin_rom [0:OCT];

  for (genvar g = 0; g <= OCT; g++) begin : g_rom
    localparam real ANG = 2.0 * 3.14159265358979323846 * real'(g) / real'(NMAX);
    localparam int  CV  = int'($floor($cos(ANG) * 131072.0 + 0.5));
    localparam int  SV  = int'($floor($sin(ANG) * 131072.0 + 0.5));
    assign cos_rom[g] = r2fft_pkg::TW_W'(CV);
    assign sin_rom[g] = r2fft_pkg::TW_W'(SV);
  end

  logic [KW:0]                       kx;
  logic [KW:0]                       diff;
  logic [OW-1:0]                     oidx;
  logic [1:0]                        quad;
  logic signed [r2fft_pkg::TW_W-1:0] c;
  logic signed [r2fft_pkg::TW_W-1:0] s;
  logic signed [r2fft_pkg::TW_W-1:0] re_nxt;
  logic signed [r2fft_pkg::TW_W-1:0] sn;
  logic signed [r2fft_pkg::TW_W-1:0] im_nxt;
  logic signed [r2fft_pkg::TW_W-1:0] w_re_r;
  logic signed [r2fft_pkg::TW_W-1:0] w_im_r;

  always_comb begin
    kx = {1'b0, idx};
    if (kx <= OCT1) begin
      diff = kx;
      quad = 2'd0;
    end else if (kx <= OCT2) begin
      diff = OCT2 - kx;
      quad = 2'd1;
    end else if (kx <= OCT3) begin
      diff = kx - OCT2;
      quad = 2'd2;
    end else begin
      diff = OCT4 - kx;
      quad = 2'd3;
    end
    oidx = diff[OW-1:0];
    c = cos_rom[oidx];
    s = sin_rom[oidx];
    case (quad)
      2'd0: begin
        re_nxt = c;
        sn     = s;
      end
      2'd1: begin
        re_nxt = s;
        sn     = c;
      end
      2'd2: begin
        re_nxt = -s;
        sn     = c;
      end
      default: begin
        re_nxt = -c;
        sn     = s;
      end
    endcase
    im_nxt = inverse ? sn : -sn;
  end

  always_ff @(posedge clk) begin
    w_re_r <= re_nxt;
    w_im_r <= im_nxt;
  end

  assign w_re = w_re_r;
  assign w_im = w_im_r;

endmodule

@@ rtl/core/r2fft_bfly.sv @@
// ----------------------------------------------------------------------------
// r2fft_bfly
// Two-stage radix-2 butterfly: registered products, then rounded sum and
// saturation of both outputs.
// ----------------------------------------------------------------------------
module r2fft_bfly (
  input  logic                                  clk,
  input  r2fft_pkg::bfly_ctl_t                  ctl,
  input  logic [r2fft_pkg::CPLX_W-1:0]          rd_data,
  input  logic signed [r2fft_pkg::TW_W-1:0]     w_re,
  input  logic signed [r2fft_pkg::TW_W-1:0]     w_im,
  output logic [r2fft_pkg::CPLX_W-1:0]          res_a,
  output logic [r2fft_pkg::CPLX_W-1:0]          res_b
);

  localparam int W = r2fft_pkg::WORD_W;

  logic [r2fft_pkg::CPLX_W-1:0]           a_r;
  logic signed [r2fft_pkg::PROD_W-1:0]    p_rr_r;
  logic signed [r2fft_pkg::PROD_W-1:0]    p_ii_r;
  logic signed [r2fft_pkg::PROD_W-1:0]    p_ri_r;
  logic signed [r2fft_pkg::PROD_W-1:0]    p_ir_r;
  logic [r2fft_pkg::CPLX_W-1:0]           res_a_r;
  logic [r2fft_pkg::CPLX_W-1:0]           res_b_r;

  logic signed [W-1:0]                    xr;
  logic signed [W-1:0]                    xi;
  logic signed [W-1:0]                    ur;
  logic signed [W-1:0]                    ui;
  logic signed [r2fft_pkg::TSUM_W-1:0]    tsum_r;
  logic signed [r2fft_pkg::TSUM_W-1:0]    tsum_i;
  logic signed [r2fft_pkg::T_W-1:0]       tr;
  logic signed [r2fft_pkg::T_W-1:0]       ti;
  logic signed [r2fft_pkg::ACC_W-1:0]     ar;
  logic signed [r2fft_pkg::ACC_W-1:0]     ai;
  logic signed [r2fft_pkg::ACC_W-1:0]     br;
  logic signed [r2fft_pkg::ACC_W-1:0]     bi;

  localparam logic signed [r2fft_pkg::TSUM_W-1:0] RND =
    r2fft_pkg::TSUM_W'(64'sd1 <<< (r2fft_pkg::TW_FRAC - 1));

  always_comb begin
    xr = rd_data[2*W-1:W];
    xi = rd_data[W-1:0];
    ur = a_r[2*W-1:W];
    ui = a_r[W-1:0];
    tsum_r = r2fft_pkg::TSUM_W'(p_rr_r) - r2fft_pkg::TSUM_W'(p_ii_r) + RND;
    tsum_i = r2fft_pkg::TSUM_W'(p_ri_r) + r2fft_pkg::TSUM_W'(p_ir_r) + RND;
    tr = tsum_r[r2fft_pkg::TSUM_W-1:r2fft_pkg::TW_FRAC];
    ti = tsum_i[r2fft_pkg::TSUM_W-1:r2fft_pkg::TW_FRAC];
    ar = r2fft_pkg::ACC_W'(ur) + r2fft_pkg::ACC_W'(tr);
    ai = r2fft_pkg::ACC_W'(ui) + r2fft_pkg::ACC_W'(ti);
    br = r2fft_pkg::ACC_W'(ur) - r2fft_pkg::ACC_W'(tr);
    bi = r2fft_pkg::ACC_W'(ui) - r2fft_pkg::ACC_W'(ti);
  end

  always_ff @(posedge clk) begin
    if (ctl.cap_a) begin
      a_r <= rd_data;
    end
    if (ctl.mul_en) begin
      p_rr_r <= r2fft_pkg::PROD_W'(w_re) * r2fft_pkg::PROD_W'(xr);
      p_ii_r <= r2fft_pkg::PROD_W'(w_im) * r2fft_pkg::PROD_W'(xi);
      p_ri_r <= r2fft_pkg::PROD_W'(w_re) * r2fft_pkg::PROD_W'(xi);
      p_ir_r <= r2fft_pkg::PROD_W'(w_im) * r2fft_pkg::PROD_W'(xr);
    end
    if (ctl.sum_en) begin
      res_a_r <= {r2fft_pkg::sat_word(ar), r2fft_pkg::sat_word(ai)};
      res_b_r <= {r2fft_pkg::sat_word(br), r2fft_pkg::sat_word(bi)};
    end
  end

  assign res_a = res_a_r;
  assign res_b = res_b_r;

endmodule

@@ sim/tb_radix2_fft_ifft.sv @@
// ----------------------------------------------------------------------------
// tb_radix2_fft_ifft
// Self-checking testbench of the radix-2 FFT/IFFT block. A short table of
// directed commands is followed by random frames of loads and reads under
// several transform lengths and both directions. Each read result is checked
// against the table's expected bin or an in-bench fixed-point model.
// ----------------------------------------------------------------------------
module tb_radix2_fft_ifft;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NMAX = 1024;
  localparam int OCT = NMAX / 8;
  localparam logic [63:0] PI_Q62 = 64'hC90FDAA22168C235;
  localparam int ITEMS = 1150;

  typedef struct {
    r2fft_pkg::in_t  stim;
    bit              typed;
    r2fft_pkg::out_t want;
  } dir_row_t;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  r2fft_pkg::in_t in_data;
  logic out_valid;
  r2fft_pkg::out_t out_data;
  logic cfg_we;
  logic [r2fft_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [r2fft_pkg::CFG_W-1:0] cfg_data;

  int cos_q17 [NMAX/2];
  int sin_q17 [NMAX/2];
  logic signed [r2fft_pkg::WORD_W-1:0] frame_re [NMAX];
  logic signed [r2fft_pkg::WORD_W-1:0] frame_im [NMAX];
  int unsigned load_cnt;
  int unsigned read_cnt;
  bit frame_valid;
  int unsigned log2_reg;
  bit inv_reg;
  int unsigned written_hi;

  r2fft_pkg::out_t pending_bins [$];
  int mismatches;
  int items_sent;
  bit no_gaps;
  dir_row_t dir_rows [11];

  radix2_fft_ifft dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .cfg_we(cfg_we),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [63:0] mul_q62(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[125:62];
  endfunction

  task automatic octant(input int unsigned b, output int c, output int s);
    logic [63:0] x, x2, ss, st, cs, ct;
    logic [63:0] i;
    x = (PI_Q62 >> 9) * 64'(b);
    x2 = mul_q62(x, x);
    ss = x;
    st = x;
    cs = 64'd1 << 62;
    ct = 64'd1 << 62;
    for (i = 1; i <= 12; i++) begin
      st = mul_q62(st, x2) / ((2 * i) * (2 * i + 1));
      ct = mul_q62(ct, x2) / ((2 * i - 1) * (2 * i));
      if (i[0]) begin
        ss = ss - st;
        cs = cs - ct;
      end else begin
        ss = ss + st;
        cs = cs + ct;
      end
    end
    s = int'((ss + (64'd1 << 44)) >> 45);
    c = int'((cs + (64'd1 << 44)) >> 45);
  endtask

  task automatic build_twiddles();
    int c, s;
    for (int k = 0; k < NMAX / 2; k++) begin
      if (k <= OCT) begin
        octant(k, c, s);
        cos_q17[k] = c;
        sin_q17[k] = s;
      end else if (k <= 2 * OCT) begin
        octant(2 * OCT - k, c, s);
        cos_q17[k] = s;
        sin_q17[k] = c;
      end else if (k <= 3 * OCT) begin
        octant(k - 2 * OCT, c, s);
        cos_q17[k] = -s;
        sin_q17[k] = c;
      end else begin
        octant(4 * OCT - k, c, s);
        cos_q17[k] = -c;
        sin_q17[k] = s;
      end
    end
  endtask

  function automatic int unsigned eff_log2(int unsigned l);
    if (l < 1) return 1;
    if (l > 10) return 10;
    return l;
  endfunction

  function automatic logic signed [r2fft_pkg::WORD_W-1:0] clip28(longint v);
    if (v > 134217727) return 28'sh7FFFFFF;
    if (v < -134217728) return 28'sh8000000;
    return v[r2fft_pkg::WORD_W-1:0];
  endfunction

  task automatic run_transform();
    int unsigned lg, n, r, a, m, half, ti, bi;
    longint wr, wi, xr, xi, tr, tm, ur, ui;
    logic signed [r2fft_pkg::WORD_W-1:0] t;
    lg = eff_log2(log2_reg);
    n = 1 << lg;
    for (int unsigned i = 0; i < n; i++) begin
      r = 0;
      a = i;
      for (int unsigned j = 0; j < lg; j++) begin
        r = (r << 1) | (a & 1);
        a = a >> 1;
      end
      if (r > i) begin
        t = frame_re[i]; frame_re[i] = frame_re[r]; frame_re[r] = t;
        t = frame_im[i]; frame_im[i] = frame_im[r]; frame_im[r] = t;
      end
    end
    for (int unsigned s = 1; s <= lg; s++) begin
      m = 1 << s;
      half = m >> 1;
      for (int unsigned k = 0; k < n; k += m) begin
        for (int unsigned j = 0; j < half; j++) begin
          a = k + j;
          bi = a + half;
          ti = j << (10 - s);
          wr = cos_q17[ti];
          wi = inv_reg ? longint'(sin_q17[ti]) : -longint'(sin_q17[ti]);
          xr = frame_re[bi];
          xi = frame_im[bi];
          tr = (wr * xr - wi * xi + 65536) >>> 17;
          tm = (wr * xi + wi * xr + 65536) >>> 17;
          ur = frame_re[a];
          ui = frame_im[a];
          frame_re[a] = clip28(ur + tr);
          frame_im[a] = clip28(ui + tm);
          frame_re[bi] = clip28(ur - tr);
          frame_im[bi] = clip28(ui - tm);
        end
      end
    end
    if (inv_reg) begin
      for (int unsigned i = 0; i < n; i++) begin
        frame_re[i] = frame_re[i] >>> lg;
        frame_im[i] = frame_im[i] >>> lg;
      end
    end
  endtask

  task automatic fft_model_step(input r2fft_pkg::in_t it, output bit has_bin,
                                output r2fft_pkg::out_t bin);
    int unsigned n;
    int unsigned idx;
    n = 1 << eff_log2(log2_reg);
    bin = '0;
    has_bin = 1'b0;
    if (it.cmd == r2fft_pkg::CMD_LOAD) begin
      idx = load_cnt % NMAX;
      frame_re[idx] = r2fft_pkg::WORD_W'(it.sample_real);
      frame_im[idx] = r2fft_pkg::WORD_W'(it.sample_imag);
      if (idx + 1 > written_hi) written_hi = idx + 1;
      frame_valid = 1'b0;
      load_cnt++;
      if (load_cnt >= n) begin
        run_transform();
        load_cnt = 0;
        read_cnt = 0;
        frame_valid = 1'b1;
      end
    end else begin
      has_bin = 1'b1;
      if (frame_valid) begin
        if (read_cnt >= n) read_cnt = 0;
        bin.bin_real = frame_re[read_cnt];
        bin.bin_imag = frame_im[read_cnt];
        bin.bin_number = r2fft_pkg::BIN_W'(read_cnt);
        bin.last_bin = (read_cnt == n - 1);
        bin.frame_ready = 1'b1;
        read_cnt++;
        if (read_cnt >= n) read_cnt = 0;
      end
    end
  endtask

  function automatic r2fft_pkg::out_t mk_bin(int re, int im, int num, bit last, bit rdy);
    r2fft_pkg::out_t o;
    o.bin_real = r2fft_pkg::WORD_W'(re);
    o.bin_imag = r2fft_pkg::WORD_W'(im);
    o.bin_number = r2fft_pkg::BIN_W'(num);
    o.last_bin = last;
    o.frame_ready = rdy;
    return o;
  endfunction

  function automatic r2fft_pkg::in_t mk_cmd(logic cmd, int re, int im);
    r2fft_pkg::in_t v;
    v.cmd = cmd;
    v.sample_real = r2fft_pkg::SAMPLE_W'(re);
    v.sample_imag = r2fft_pkg::SAMPLE_W'(im);
    return v;
  endfunction

  function automatic logic [15:0] rand_sample();
    case ($urandom_range(0, 9))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'hFFFF;
      3: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic int gap_len();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  task automatic issue(input r2fft_pkg::in_t it, input bit typed, input r2fft_pkg::out_t want);
    bit has_bin;
    r2fft_pkg::out_t bin;
    int g;
    start <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (busy);
    fft_model_step(it, has_bin, bin);
    if (has_bin) pending_bins.push_back(typed ? want : bin);
    items_sent++;
    g = gap_len();
    if (g > 0) begin
      start <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic issue_rand(input logic cmd);
    issue(mk_cmd(cmd, rand_sample(), rand_sample()), 1'b0, '0);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_bins.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_reg(input logic [r2fft_pkg::CFG_IDX_W-1:0] idx, input int unsigned val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= r2fft_pkg::CFG_W'(val);
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == r2fft_pkg::CFG_LOG2_POINTS) log2_reg = val & 4'hF;
    else inv_reg = val[0];
    @(posedge clk);
  endtask

  task automatic set_length(input int unsigned val);
    if (frame_valid && (1 << eff_log2(val)) > written_hi) val = 1;
    write_reg(r2fft_pkg::CFG_LOG2_POINTS, val);
  endtask

  task automatic big_frame(input int unsigned lg, input bit inv);
    drain();
    write_reg(r2fft_pkg::CFG_INVERSE_MODE, inv);
    write_reg(r2fft_pkg::CFG_LOG2_POINTS, lg);
    for (int i = 0; i < NMAX; i++) issue_rand(r2fft_pkg::CMD_LOAD);
    for (int i = 0; i < 40; i++) issue_rand(r2fft_pkg::CMD_READ);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_bins.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result %p", out_data);
      end else begin
        r2fft_pkg::out_t want;
        want = pending_bins.pop_front();
        if (out_data.bin_real !== want.bin_real || out_data.bin_imag !== want.bin_imag ||
            out_data.bin_number !== want.bin_number ||
            out_data.last_bin !== want.last_bin ||
            out_data.frame_ready !== want.frame_ready) begin
          mismatches++;
          if (mismatches <= 10) $display("Mismatch: expected %p, got %p", want, out_data);
        end
      end
    end
  end

  initial begin
    #20ms;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    int n, reads;
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    mismatches = 0;
    items_sent = 0;
    no_gaps = 1'b0;
    load_cnt = 0;
    read_cnt = 0;
    frame_valid = 1'b0;
    log2_reg = 10;
    inv_reg = 1'b0;
    written_hi = 0;
    build_twiddles();

    dir_rows[0] = '{mk_cmd(r2fft_pkg::CMD_READ, 0, 0), 1'b1, mk_bin(0, 0, 0, 0, 0)};
    dir_rows[1] = '{mk_cmd(r2fft_pkg::CMD_LOAD, 32767, -32768), 1'b0, '0};
    dir_rows[2] = '{mk_cmd(r2fft_pkg::CMD_LOAD, -32768, 32767), 1'b0, '0};
    dir_rows[3] = '{mk_cmd(r2fft_pkg::CMD_READ, -1, -1), 1'b1, mk_bin(-1, -1, 0, 0, 1)};
    dir_rows[4] = '{mk_cmd(r2fft_pkg::CMD_READ, 0, 0), 1'b1,
                    mk_bin(65535, -65535, 1, 1, 1)};
    dir_rows[5] = '{mk_cmd(r2fft_pkg::CMD_READ, 0, 0), 1'b1, mk_bin(-1, -1, 0, 0, 1)};
    dir_rows[6] = '{mk_cmd(r2fft_pkg::CMD_LOAD, 0, -1), 1'b0, '0};
    dir_rows[7] = '{mk_cmd(r2fft_pkg::CMD_READ, 0, 0), 1'b1, mk_bin(0, 0, 0, 0, 0)};
    dir_rows[8] = '{mk_cmd(r2fft_pkg::CMD_LOAD, -1, 0), 1'b0, '0};
    dir_rows[9] = '{mk_cmd(r2fft_pkg::CMD_READ, 0, 0), 1'b0, '0};
    dir_rows[10] = '{mk_cmd(r2fft_pkg::CMD_READ, 0, 0), 1'b0, '0};

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_reg(r2fft_pkg::CFG_LOG2_POINTS, 1);
    foreach (dir_rows[i]) issue(dir_rows[i].stim, dir_rows[i].typed, dir_rows[i].want);

    while (items_sent < ITEMS - (NMAX + 40)) begin
      if ($urandom_range(0, 3) == 0) begin
        drain();
        write_reg(r2fft_pkg::CFG_INVERSE_MODE, $urandom_range(0, 1));
        set_length($urandom_range(0, 6));
      end
      no_gaps = ($urandom_range(0, 4) == 0);
      n = 1 << eff_log2(log2_reg);
      if ($urandom_range(0, 99) < 85) begin
        for (int i = load_cnt; i < n; i++) issue_rand(r2fft_pkg::CMD_LOAD);
        reads = $urandom_range(n, 2 * n + 1);
        for (int i = 0; i < reads; i++) issue_rand(r2fft_pkg::CMD_READ);
      end else begin
        reads = $urandom_range(1, 8);
        for (int i = 0; i < reads; i++) begin
          if (!frame_valid && (1 << eff_log2(log2_reg)) > written_hi)
            issue_rand(r2fft_pkg::CMD_LOAD);
          else
            issue_rand($urandom_range(0, 1));
        end
      end
    end
    no_gaps = 1'b0;

    big_frame(15, 1'b1);

    drain();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending_bins.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/r2fft_pkg.sv
rtl/core/r2fft_ram.sv
rtl/core/r2fft_twiddle.sv
rtl/core/r2fft_bfly.sv
rtl/core/radix2_fft_ifft.sv
sim/tb_radix2_fft_ifft.sv
